[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fmr_pkg.sv]
package fmr_pkg;

	// Field widths and parameter defaults
	localparam int ADDR_IN_W         = 64;
	localparam int TOTAL_W           = 32;
	localparam int TABLE_DEPTH_DEF   = 256;
	localparam int ADDRESS_WIDTH_DEF = 64;

	// Event kinds
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_WRONG = 2'd3;

	// Entry phases
	localparam logic [1:0] PHASE_NEW   = 2'd0;
	localparam logic [1:0] PHASE_ALLOC = 2'd1;
	localparam logic [1:0] PHASE_FREED = 2'd2;

	// Sequencer steps
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
	localparam logic [STEP_W-1:0] ST_PRIME = 3'd1;
	localparam logic [STEP_W-1:0] ST_SCAN  = 3'd2;
	localparam logic [STEP_W-1:0] ST_MISS  = 3'd3;
	localparam logic [STEP_W-1:0] ST_UPD   = 3'd4;
	localparam logic [STEP_W-1:0] ST_END   = 3'd5;

	// Jump conditions
	localparam logic [1:0] JMP_NONE     = 2'd0;
	localparam logic [1:0] JMP_DISPATCH = 2'd1;
	localparam logic [1:0] JMP_SCAN     = 2'd2;
	localparam logic [1:0] JMP_EMIT     = 2'd3;

	// One control word of the microprogram
	typedef struct packed {
		logic              accept;  // take an event beat
		logic              rd_first; // read entry 0
		logic              scan;    // compare entry, read the following one
		logic              insert;  // allocate a slot for a new address
		logic              update;  // write back entry, state, result
		logic              finish;  // trace end: report and clear
		logic [1:0]        jmp;
		logic [STEP_W-1:0] next;
	} ctrl_t;

	// Microprogram ROM
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '0;
		c.next = ST_IDLE;
		unique case (step)
			ST_IDLE: begin
				c.accept = 1'b1;
				c.jmp    = JMP_DISPATCH;
				c.next   = ST_IDLE;
			end
			ST_PRIME: begin
				c.rd_first = 1'b1;
				c.next     = ST_SCAN;
			end
			ST_SCAN: begin
				c.scan = 1'b1;
				c.jmp  = JMP_SCAN;
				c.next = ST_SCAN;
			end
			ST_MISS: begin
				c.insert = 1'b1;
				c.next   = ST_UPD;
			end
			ST_UPD: begin
				c.update = 1'b1;
				c.jmp    = JMP_EMIT;
				c.next   = ST_IDLE;
			end
			ST_END: begin
				c.finish = 1'b1;
				c.jmp    = JMP_EMIT;
				c.next   = ST_IDLE;
			end
			default: begin
				c.next = ST_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

[rtl/fmr_ram.sv]
module fmr_ram #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/free_then_realloc_monitor_unit.sv]
// Allocation-event monitor.
// Event channel: event_valid/event_ready carry event_kind and address (low
// ADDRESS_WIDTH bits kept). Result channel: result_valid/result_ready carry
// violation, wrong_event, table_full, trace_done and violation_total; one
// result beat per event beat.
// A small microprogram steps through each event. A trace end goes straight
// from the accepting step to its reporting step. Any other event scans the
// address table one entry per cycle through the table RAM read port (unless
// the table is empty); a hit in entry k ends the scan there, a miss runs over
// all stored entries, at most TABLE_DEPTH.
// One event is in flight at a time; the next beat is taken in the cycle
// after the result is registered.
// The result register holds while result_ready is low; a finished event
// waits in its last step until the register is free, and no new event is
// taken meanwhile.
// Reset clears the fill count, last-freed holder and violation count at once;
// the table RAM needs no clearing pass, entries past the fill count are
// never used.
`include "assert_macros.svh"

module free_then_realloc_monitor_unit #(
	parameter int TABLE_DEPTH   = fmr_pkg::TABLE_DEPTH_DEF,
	parameter int ADDRESS_WIDTH = fmr_pkg::ADDRESS_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         event_valid,
	output logic                         event_ready,
	input  logic [1:0]                   event_kind,
	input  logic [fmr_pkg::ADDR_IN_W-1:0] address,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic                         violation,
	output logic                         wrong_event,
	output logic                         table_full,
	output logic                         trace_done,
	output logic [fmr_pkg::TOTAL_W-1:0]  violation_total
);
	import fmr_pkg::*;

	localparam int IDXW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNTW  = $clog2(TABLE_DEPTH + 1);
	localparam int WORDW = ADDRESS_WIDTH + 2;

	// Sequencer
	logic [STEP_W-1:0] step_q, step_d;
	ctrl_t             cw;

	// Event and search registers
	logic [1:0]               kind_q;
	logic [ADDRESS_WIDTH-1:0] addr_q;
	logic [IDXW-1:0]          idx_q;
	logic [IDXW-1:0]          slot_q;
	logic [1:0]               phase_q;
	logic                     stored_q;
	logic                     full_q;

	// Monitor state
	logic [CNTW-1:0]          used_q;
	logic [ADDRESS_WIDTH-1:0] lf_addr_q;
	logic                     lf_valid_q;
	logic [TOTAL_W-1:0]       count_q;

	// Result register
	logic               res_valid_q;
	logic               res_viol_q, res_wrong_q, res_full_q, res_done_q;
	logic [TOTAL_W-1:0] res_total_q;

	// RAM ports
	logic             ram_we, ram_re;
	logic [IDXW-1:0]  ram_waddr, ram_raddr;
	logic [WORDW-1:0] ram_wdata, ram_rdata;

	// Datapath terms
	logic                     in_fire, out_free, emit;
	logic                     hit, last_entry, has_room;
	logic [ADDRESS_WIDTH-1:0] in_addr;
	logic                     viol;
	logic [1:0]               new_phase;
	logic [TOTAL_W-1:0]       count_upd;

	assign cw        = ucode(step_q);
	assign in_addr   = address[ADDRESS_WIDTH-1:0];
	assign in_fire   = event_valid && cw.accept;
	assign out_free  = !res_valid_q || result_ready;
	assign emit      = (cw.update || cw.finish) && out_free;
	assign hit       = (ram_rdata[ADDRESS_WIDTH-1:0] == addr_q);
	assign last_entry = ((CNTW'(idx_q) + 1'b1) == used_q);
	assign has_room  = (used_q < CNTW'(TABLE_DEPTH));

	assign viol = (kind_q == KIND_ALLOC) && (phase_q == PHASE_FREED) &&
		lf_valid_q && (lf_addr_q == addr_q);

	// Phase written back for the entry
	always_comb begin
		case (kind_q)
			KIND_ALLOC: new_phase = PHASE_ALLOC;
			KIND_FREE:  new_phase = PHASE_FREED;
			default:    new_phase = phase_q;
		endcase
	end

	assign count_upd = (viol && (count_q != '1)) ? count_q + 1'b1 : count_q;

	// Next step: default successor or conditional jump
	always_comb begin
		step_d = cw.next;
		unique case (cw.jmp)
			JMP_NONE: step_d = cw.next;
			JMP_DISPATCH: begin
				if (!in_fire) begin
					step_d = ST_IDLE;
				end else if (event_kind == KIND_END) begin
					step_d = ST_END;
				end else if (used_q == '0) begin
					step_d = ST_MISS;
				end else begin
					step_d = ST_PRIME;
				end
			end
			JMP_SCAN: begin
				if (hit) begin
					step_d = ST_UPD;
				end else if (last_entry) begin
					step_d = ST_MISS;
				end else begin
					step_d = ST_SCAN;
				end
			end
			JMP_EMIT: step_d = out_free ? cw.next : step_q;
			default:  step_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Table RAM access
	assign ram_re    = cw.rd_first || cw.scan;
	assign ram_raddr = cw.scan ? idx_q + 1'b1 : '0;
	assign ram_we    = cw.update && out_free && stored_q;
	assign ram_waddr = slot_q;
	assign ram_wdata = {new_phase, addr_q};

	fmr_ram #(
		.WIDTH(WORDW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Event capture, search and slot selection
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q   <= event_kind;
			addr_q   <= in_addr;
			idx_q    <= '0;
			stored_q <= 1'b0;
			full_q   <= 1'b0;
			phase_q  <= PHASE_NEW;
		end
		if (cw.scan) begin
			if (hit) begin
				slot_q   <= idx_q;
				phase_q  <= ram_rdata[WORDW-1:ADDRESS_WIDTH];
				stored_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (cw.insert) begin
			phase_q  <= PHASE_NEW;
			slot_q   <= used_q[IDXW-1:0];
			stored_q <= has_room;
			full_q   <= !has_room;
		end
	end

	// Monitor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			lf_addr_q  <= '0;
			lf_valid_q <= 1'b0;
			count_q    <= '0;
		end else begin
			if (cw.insert && has_room) begin
				used_q <= used_q + 1'b1;
			end
			if (cw.update && out_free) begin
				count_q <= count_upd;
				if (kind_q == KIND_FREE) begin
					lf_addr_q  <= addr_q;
					lf_valid_q <= 1'b1;
				end else if (kind_q == KIND_WRONG) begin
					lf_valid_q <= 1'b0;
				end
			end
			if (cw.finish && out_free) begin
				used_q  <= '0;
				count_q <= '0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_viol_q  <= cw.update && viol;
			res_wrong_q <= cw.update && (kind_q == KIND_WRONG);
			res_full_q  <= cw.update && full_q;
			res_done_q  <= cw.finish;
			res_total_q <= cw.finish ? count_q : count_upd;
		end
	end

	assign event_ready     = cw.accept;
	assign result_valid    = res_valid_q;
	assign violation       = res_viol_q;
	assign wrong_event     = res_wrong_q;
	assign table_full      = res_full_q;
	assign trace_done      = res_done_q;
	assign violation_total = res_total_q;

	// Checks
	`ASSERT_CLK(a_used_bound, used_q <= CNTW'(TABLE_DEPTH), "fill count past table depth")
	`ASSERT_CLK(a_scan_range, (step_q == ST_SCAN) |-> (CNTW'(idx_q) < used_q), "scan past fill")
	`ASSERT_CLK(a_end_clears, (cw.finish && out_free) |=> (used_q == '0 && count_q == '0), "trace end did not clear")
	`ASSERT_CLK(a_flag_mix, result_valid |-> !(violation && (wrong_event || trace_done)), "bad flag mix")

endmodule
